// ----- hw/rtl/lqs_pkg.sv -----
// shared types and constants for the linear queue with search
`default_nettype none

package lqs_pkg;

	localparam int unsigned DEPTH_DEF = 16;   // storage slots
	localparam int unsigned DATA_W    = 32;   // stored word width
	localparam int unsigned CNT_OUT_W = 5;    // width of count and position results
	localparam int unsigned CAP_W     = 5;    // capacity register width
	localparam int unsigned PADDR_W   = 3;    // config byte address width
	localparam int unsigned PDATA_W   = 32;   // config data width

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// config register index (byte address / 4)
	localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

	// command codes
	localparam logic [1:0] CMD_ENQUEUE = 2'd0;
	localparam logic [1:0] CMD_DEQUEUE = 2'd1;
	localparam logic [1:0] CMD_SEARCH  = 2'd2;
	localparam logic [1:0] CMD_NOP     = 2'd3;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_SCAN,
		SEQ_FRONT,
		SEQ_FDATA
	} seq_state_t;

endpackage : lqs_pkg

`default_nettype wire

// ----- hw/rtl/linear_queue_with_search.sv -----
// linear (non-circular) array queue of signed words with front-to-rear search
//
//   channel   | signals                                         | transfer when
//   ----------+-------------------------------------------------+--------------------------
//   command   | start, busy, command, data_in                   | start && !busy at clk edge
//   result    | done, status, data_out, found_position,         | every cycle done is high
//             | entry_count, is_empty, front_word               |
//   config    | psel, penable, pwrite, paddr, pwdata, prdata,   | psel && penable && pwrite
//             | pready                                          |
//
// enqueue, dequeue and the unused command go through the front and fdata states to done
// search scans front to rear up to the first match (no scan on an empty queue): one memory
//   read port feeds the single comparator, one slot per cycle
// done is high for exactly one cycle; the receiver cannot stall it
// arst_n clears counters, capacity (to 16) and the sequencer; slot contents stay undefined
// a new command can be taken in the same cycle that done is high
`default_nettype none

module linear_queue_with_search #(
	parameter int unsigned DEPTH = lqs_pkg::DEPTH_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	// command channel
	input  wire                                   start,
	output logic                                  busy,
	input  wire        [1:0]                      command,
	input  wire signed [lqs_pkg::DATA_W-1:0]      data_in,
	// result channel
	output logic                                  done,
	output logic       [1:0]                      status,
	output logic signed [lqs_pkg::DATA_W-1:0]     data_out,
	output logic       [lqs_pkg::CNT_OUT_W-1:0]   found_position,
	output logic       [lqs_pkg::CNT_OUT_W-1:0]   entry_count,
	output logic                                  is_empty,
	output logic signed [lqs_pkg::DATA_W-1:0]     front_word,
	// config port
	input  wire                                   psel,
	input  wire                                   penable,
	input  wire                                   pwrite,
	input  wire        [lqs_pkg::PADDR_W-1:0]     paddr,
	input  wire        [lqs_pkg::PDATA_W-1:0]     pwdata,
	output logic       [lqs_pkg::PDATA_W-1:0]     prdata,
	output logic                                  pready
);

	// slot address and counter widths follow the storage depth
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	// common width for comparing the counter against the capacity register
	localparam int unsigned MW = (CW > lqs_pkg::CAP_W) ? CW : lqs_pkg::CAP_W;
	localparam int unsigned DW = lqs_pkg::DATA_W;

	// sequencer
	lqs_pkg::seq_state_t state_q, state_d;

	// queue pointers: live entries are slots fs_q .. wc_q-1
	logic [CW-1:0] wc_q;                 // slots written so far
	logic [CW-1:0] fs_q;                 // front slot
	logic [lqs_pkg::CAP_W-1:0] cap_q;   // usable capacity

	// slot memory, one write and one registered read per cycle
	logic [DW-1:0] slots_q [DEPTH];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] raddr;
	logic          mem_we;

	// working registers of the current command
	logic [DW-1:0]       key_q;
	logic [DW-1:0]       front_q;       // copy of the front slot
	logic [DW-1:0]       removed_q;
	lqs_pkg::status_t    st_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       scan_q;        // next slot address issued by the scan
	logic [CW-1:0]       chk_idx_q;     // slot whose word sits in rdata_q
	logic                chk_vld_q;     // rdata_q holds a scanned word

	// result registers
	logic                            done_q;
	lqs_pkg::status_t                res_status_q;
	logic [DW-1:0]                   res_data_q;
	logic [lqs_pkg::CNT_OUT_W-1:0]   res_pos_q;
	logic [lqs_pkg::CNT_OUT_W-1:0]   res_count_q;
	logic                            res_empty_q;
	logic [DW-1:0]                   res_front_q;

	logic accept;
	logic full;
	logic empty;
	logic scan_more;   // scan address still inside the live range
	logic hit;         // the shared comparator found the key
	logic issue;       // scan reads one more slot this cycle
	logic cfg_wr;

	// ---------------------------------------------------------------
	// status decode
	// ---------------------------------------------------------------
	assign accept    = start && (state_q == lqs_pkg::SEQ_IDLE);
	// overflow once the write slot reaches capacity or storage end
	assign full      = (MW'(wc_q) >= MW'(cap_q)) || (wc_q >= CW'(DEPTH));
	assign empty     = (fs_q >= wc_q);
	assign scan_more = (scan_q < wc_q);
	assign hit       = chk_vld_q && (rdata_q == key_q);
	assign issue     = (state_q == lqs_pkg::SEQ_SCAN) && scan_more && !hit;
	// an enqueue that fits writes its word at the accepting edge
	assign mem_we    = accept && (command == lqs_pkg::CMD_ENQUEUE) && !full;

	// ---------------------------------------------------------------
	// sequencer: next state and memory read address
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		raddr   = fs_q[AW-1:0];
		unique case (state_q)
			lqs_pkg::SEQ_IDLE: begin
				if (start) begin
					if ((command == lqs_pkg::CMD_SEARCH) && !empty) begin
						state_d = lqs_pkg::SEQ_SCAN;
					end else begin
						state_d = lqs_pkg::SEQ_FRONT;
					end
				end
			end
			lqs_pkg::SEQ_SCAN: begin
				// one slot read per cycle, compared the cycle after
				raddr = scan_q[AW-1:0];
				if (hit) begin
					state_d = lqs_pkg::SEQ_FRONT;
				end else if (!chk_vld_q && !scan_more) begin
					state_d = lqs_pkg::SEQ_FRONT;
				end
			end
			lqs_pkg::SEQ_FRONT: begin
				// fetch the front slot after the pointers have settled
				state_d = lqs_pkg::SEQ_FDATA;
			end
			lqs_pkg::SEQ_FDATA: begin
				state_d = lqs_pkg::SEQ_IDLE;
			end
			default: begin
				state_d = lqs_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lqs_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// slot memory
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slots_q[wc_q[AW-1:0]] <= data_in;
		end
		rdata_q <= slots_q[raddr];
	end

	// ---------------------------------------------------------------
	// control registers: pointers, capacity, strobe
	// ---------------------------------------------------------------
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q      <= '0;
			fs_q      <= '0;
			cap_q     <= lqs_pkg::CAP_RESET;
			done_q    <= 1'b0;
			chk_vld_q <= 1'b0;
		end else begin
			done_q    <= (state_q == lqs_pkg::SEQ_FDATA);
			chk_vld_q <= issue;
			if (cfg_wr && (paddr[lqs_pkg::PADDR_W-1:2] == lqs_pkg::REG_CAPACITY)) begin
				cap_q <= pwdata[lqs_pkg::CAP_W-1:0];
			end
			if (mem_we) begin
				wc_q <= wc_q + 1'b1;
			end
			if (accept && (command == lqs_pkg::CMD_DEQUEUE) && !empty) begin
				fs_q <= fs_q + 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// working and result registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= data_in;
			// a dequeue that succeeds hands out the front copy
			removed_q <= ((command == lqs_pkg::CMD_DEQUEUE) && !empty) ? front_q : '0;
			pos_q     <= '0;
			scan_q    <= fs_q;
			unique case (command)
				lqs_pkg::CMD_ENQUEUE: begin
					st_q <= full ? lqs_pkg::STAT_OVERFLOW : lqs_pkg::STAT_OK;
				end
				lqs_pkg::CMD_DEQUEUE: begin
					st_q <= empty ? lqs_pkg::STAT_UNDERFLOW : lqs_pkg::STAT_OK;
				end
				lqs_pkg::CMD_SEARCH: begin
					st_q <= lqs_pkg::STAT_NOT_FOUND;
				end
				default: begin
					// unused command: no change, reports the queue as it stands
					st_q <= lqs_pkg::STAT_OK;
				end
			endcase
		end
		if (issue) begin
			scan_q    <= scan_q + 1'b1;
			chk_idx_q <= scan_q;
		end
		if ((state_q == lqs_pkg::SEQ_SCAN) && hit) begin
			st_q  <= lqs_pkg::STAT_OK;
			pos_q <= chk_idx_q + 1'b1;
		end
		if (state_q == lqs_pkg::SEQ_FDATA) begin
			front_q      <= rdata_q;
			res_status_q <= st_q;
			res_data_q   <= removed_q;
			res_pos_q    <= lqs_pkg::CNT_OUT_W'(pos_q);
			res_count_q  <= lqs_pkg::CNT_OUT_W'(wc_q - fs_q);
			res_empty_q  <= empty;
			res_front_q  <= empty ? '0 : rdata_q;
		end
	end

	// ---------------------------------------------------------------
	// ports
	// ---------------------------------------------------------------
	assign busy           = (state_q != lqs_pkg::SEQ_IDLE);
	assign done           = done_q;
	assign status         = res_status_q;
	assign data_out       = res_data_q;
	assign found_position = res_pos_q;
	assign entry_count    = res_count_q;
	assign is_empty       = res_empty_q;
	assign front_word     = res_front_q;

	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[lqs_pkg::PADDR_W-1:2] == lqs_pkg::REG_CAPACITY) begin
			prdata = lqs_pkg::PDATA_W'(cap_q);
		end
	end

endmodule : linear_queue_with_search

`default_nettype wire
